// ===== sv/gha_pkg.sv =====
// gha_pkg: request and response payload types and command and status codes
// for the generational handle allocator. No dependencies.
package gha_pkg;

   localparam int IDX_BITS = 10;
   localparam int VER_BITS = 8;

   localparam logic [2:0] CMD_CREATE     = 3'd0;
   localparam logic [2:0] CMD_DESTROY    = 3'd1;
   localparam logic [2:0] CMD_QUERY      = 3'd2;
   localparam logic [2:0] CMD_ACTIVATE   = 3'd3;
   localparam logic [2:0] CMD_DEACTIVATE = 3'd4;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_POOL_FULL = 2'd1;
   localparam logic [1:0] STATUS_INVALID   = 2'd2;

   typedef struct packed {
      logic [2:0]          command;
      logic [IDX_BITS-1:0] req_index;
      logic [VER_BITS-1:0] req_version;
   } req_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [IDX_BITS-1:0] handle_index;
      logic [VER_BITS-1:0] handle_version;
      logic                is_valid;
      logic                is_active;
   } rsp_type;

endpackage

// ===== sv/generational_handle_allocator.sv =====
// generational_handle_allocator: slot/version handle allocator with a LIFO free stack,
// per-slot version and active memories and one request register and one response register.
// Depends on gha_pkg.
//
//   channel   direction   handshake               payload
//   req       in          req_valid / req_stall   gha_pkg::req_type
//   rsp       out         rsp_valid / rsp_stall   gha_pkg::rsp_type
//
// One request per cycle unless the response side stalls; an accepted request waits in the request
// register, which lines up with the registered read of the version and active memories, and
// its response is loaded into the response register.
// Reset clears the free count, the pool size and both valid flags; memories are not cleared,
// a slot's entries are written when the pool grows over it.
// A stalled response holds the request register, which stalls the request side in turn.
module generational_handle_allocator #(
   parameter int MAX_SLOTS    = 1024,
   parameter int VERSION_BITS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  gha_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gha_pkg::rsp_type  rsp_data
);

   localparam int AW = $clog2(MAX_SLOTS);
   localparam int CW = $clog2(MAX_SLOTS + 1);
   localparam int VW = VERSION_BITS;
   localparam int XW = (VERSION_BITS > gha_pkg::VER_BITS) ? VERSION_BITS : gha_pkg::VER_BITS;
   localparam int PW = (CW > gha_pkg::IDX_BITS) ? CW : gha_pkg::IDX_BITS;

   logic [VW-1:0] ver_mem [MAX_SLOTS];
   logic          act_mem [MAX_SLOTS];
   logic [AW-1:0] stk_mem [MAX_SLOTS];

   gha_pkg::req_type s1_ff, s1_in;
   logic             s1_valid_ff, s1_valid_in;
   gha_pkg::rsp_type rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [CW-1:0] fc_ff, fc_in;
   logic [CW-1:0] pool_ff, pool_in;
   logic [AW-1:0] top_ff, top_in;

   logic [VW-1:0] rd_ver_ff;
   logic          rd_act_ff;
   logic [AW-1:0] stk_rd_ff;
   logic          hit_ff, hit_in;
   logic [VW-1:0] fwd_ver_ff;
   logic          fwd_act_ff;

   logic          accept, exec;
   logic [2:0]    nx_cmd;
   logic [gha_pkg::IDX_BITS-1:0] nx_idx;
   logic [AW-1:0] rd_addr;
   logic [CW-1:0] stk_rd_cnt;

   logic [VW-1:0] cur_ver;
   logic          cur_act;
   logic          handle_ok;
   logic [AW-1:0] idx_a;

   logic          mem_we;
   logic [AW-1:0] mem_wa;
   logic [VW-1:0] wr_ver;
   logic          wr_act;
   logic          stk_we;
   logic [AW-1:0] stk_wa;

   assign exec      = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !exec;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign cur_ver = hit_ff ? fwd_ver_ff : rd_ver_ff;
   assign cur_act = hit_ff ? fwd_act_ff : rd_act_ff;
   assign idx_a   = AW'(s1_ff.req_index);
   assign handle_ok = (PW'(s1_ff.req_index) < PW'(pool_ff))
                   && (XW'(cur_ver) == XW'(s1_ff.req_version));

   // execute the request held in the request register
   always_comb begin
      fc_in   = fc_ff;
      pool_in = pool_ff;
      top_in  = top_ff;
      mem_we  = 1'b0;
      mem_wa  = idx_a;
      wr_ver  = cur_ver;
      wr_act  = cur_act;
      stk_we  = 1'b0;
      stk_wa  = fc_ff[AW-1:0];
      rsp_in.status         = gha_pkg::STATUS_OK;
      rsp_in.handle_index   = s1_ff.req_index;
      rsp_in.handle_version = s1_ff.req_version;
      rsp_in.is_valid       = 1'b0;
      rsp_in.is_active      = 1'b0;
      if (exec) begin
         if (s1_ff.command == gha_pkg::CMD_CREATE) begin
            priority if (fc_ff != '0) begin
               fc_in  = fc_ff - CW'(1);
               top_in = stk_rd_ff;
               rsp_in.handle_index   = gha_pkg::IDX_BITS'(top_ff);
               rsp_in.handle_version = gha_pkg::VER_BITS'(cur_ver);
               rsp_in.is_valid       = 1'b1;
            end else if (pool_ff < CW'(MAX_SLOTS)) begin
               pool_in = pool_ff + CW'(1);
               mem_we  = 1'b1;
               mem_wa  = pool_ff[AW-1:0];
               wr_ver  = '0;
               wr_act  = 1'b0;
               rsp_in.handle_index   = gha_pkg::IDX_BITS'(pool_ff);
               rsp_in.handle_version = '0;
               rsp_in.is_valid       = 1'b1;
            end else begin
               rsp_in.status         = gha_pkg::STATUS_POOL_FULL;
               rsp_in.handle_index   = '0;
               rsp_in.handle_version = '0;
            end
         end else if (!handle_ok || s1_ff.command > gha_pkg::CMD_DEACTIVATE) begin
            rsp_in.status = gha_pkg::STATUS_INVALID;
         end else begin
            unique case (s1_ff.command)
               gha_pkg::CMD_DESTROY: begin
                  mem_we = 1'b1;
                  wr_ver = cur_ver + VW'(1);
                  wr_act = 1'b0;
                  if (fc_ff < CW'(MAX_SLOTS)) begin
                     stk_we = 1'b1;
                     fc_in  = fc_ff + CW'(1);
                     top_in = idx_a;
                  end
               end
               gha_pkg::CMD_QUERY: begin
                  rsp_in.is_valid  = 1'b1;
                  rsp_in.is_active = cur_act;
               end
               gha_pkg::CMD_ACTIVATE: begin
                  mem_we = 1'b1;
                  wr_act = 1'b1;
                  rsp_in.is_valid  = 1'b1;
                  rsp_in.is_active = 1'b1;
               end
               default: begin
                  mem_we = 1'b1;
                  wr_act = 1'b0;
                  rsp_in.is_valid = 1'b1;
               end
            endcase
         end
      end
   end

   // read addresses for the request that sits in the register next cycle
   always_comb begin
      s1_in       = accept ? req_data : s1_ff;
      s1_valid_in = accept || (s1_valid_ff && !exec);
      nx_cmd      = s1_in.command;
      nx_idx      = s1_in.req_index;
      if (nx_cmd == gha_pkg::CMD_CREATE) begin
         rd_addr = (fc_in != '0) ? top_in : pool_in[AW-1:0];
      end else begin
         rd_addr = AW'(nx_idx);
      end
      hit_in       = mem_we && (mem_wa == rd_addr);
      stk_rd_cnt   = fc_in - CW'(2);
      rsp_valid_in = exec || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fc_ff        <= '0;
         pool_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         fc_ff        <= fc_in;
         pool_ff      <= pool_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff      <= s1_in;
      top_ff     <= top_in;
      hit_ff     <= hit_in;
      fwd_ver_ff <= wr_ver;
      fwd_act_ff <= wr_act;
      if (exec) begin
         rsp_ff <= rsp_in;
      end
   end

   // version and active memories, read-first
   always_ff @(posedge clock) begin
      rd_ver_ff <= ver_mem[rd_addr];
      if (mem_we) begin
         ver_mem[mem_wa] <= wr_ver;
      end
   end

   always_ff @(posedge clock) begin
      rd_act_ff <= act_mem[rd_addr];
      if (mem_we) begin
         act_mem[mem_wa] <= wr_act;
      end
   end

   // free stack, the entry below the top is kept read for the next pop
   always_ff @(posedge clock) begin
      stk_rd_ff <= stk_mem[stk_rd_cnt[AW-1:0]];
      if (stk_we) begin
         stk_mem[stk_wa] <= idx_a;
      end
   end

endmodule
